@@ design/pipp_pkg.sv @@
package pipp_pkg;

    // Field widths of the access and result ports
    localparam int SET_IN_W = 6;
    localparam int WAY_W    = 4;
    localparam int CNT_W    = 5;
    localparam int MASK_W   = 16;
    localparam int DRAW_W   = 7;

    // Stored recency position: 0..WAYS, so one bit above the way index
    localparam int POS_W    = 5;
    localparam int MAX_WAYS = 16;

    // Access kinds
    localparam logic KIND_MISS = 1'b0;
    localparam logic KIND_HIT  = 1'b1;

    // Normal requesters promote when the low two draw bits are below this
    localparam logic [1:0] PROMOTE_NORMAL_LIMIT = 2'd3;

    // Reset value of the minimum insert distance
    localparam logic [CNT_W-1:0] MID_RESET = 5'd8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Access held while its set row is read and updated
    typedef struct packed {
        logic              kind;
        logic [WAY_W-1:0]  hit_way;
        logic [POS_W-1:0]  ins;
        logic [MASK_W-1:0] mask;
        logic              attempt;
    } op_t;

    // Result of one access
    typedef struct packed {
        logic [WAY_W-1:0] victim;
        logic [WAY_W-1:0] ins;
        logic             promoted;
    } res_t;

endpackage

@@ design/pipp_row_update.sv @@
module pipp_row_update #(
    parameter int WAYS = 16
) (
    input  logic [WAYS*pipp_pkg::POS_W-1:0] row,
    input  pipp_pkg::op_t                   op,
    output logic [WAYS*pipp_pkg::POS_W-1:0] row_new,
    output pipp_pkg::res_t                  res
);

    localparam int POS_W   = pipp_pkg::POS_W;
    localparam int WAY_W   = pipp_pkg::WAY_W;
    localparam int NWAYS   = pipp_pkg::MAX_WAYS;
    localparam int NODES   = 2 * NWAYS - 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(WAYS - 1);

    logic [POS_W-1:0] pos [NWAYS];
    logic [POS_W-1:0] pos_new [NWAYS];
    logic [POS_W-1:0] t_val [NODES];
    logic [WAY_W-1:0] t_idx [NODES];
    logic [WAY_W-1:0] victim;
    logic [POS_W-1:0] orig;
    logic [POS_W-1:0] target;
    logic [WAY_W-1:0] swap_way;
    logic             found;
    logic             hit_in_range;
    logic             do_promote;

    // Unpack the row; ways beyond WAYS read as position zero
    for (genvar g = 0; g < NWAYS; g++) begin : g_unpack
        if (g < WAYS) begin : g_live
            assign pos[g] = row[g*POS_W +: POS_W];
            assign row_new[g*POS_W +: POS_W] = pos_new[g];
        end else begin : g_pad
            assign pos[g] = '0;
        end
    end

    // Victim search: registered-free max tree, lower way wins ties
    always_comb
    begin
        for (int w = 0; w < NWAYS; w++)
        begin
            t_val[NWAYS - 1 + w] = op.mask[w] ? pos[w] : '0;
            t_idx[NWAYS - 1 + w] = WAY_W'(w);
        end
        for (int n = NWAYS - 2; n >= 0; n--)
        begin
            if (t_val[2*n+2] > t_val[2*n+1])
            begin
                t_val[n] = t_val[2*n+2];
                t_idx[n] = t_idx[2*n+2];
            end
            else
            begin
                t_val[n] = t_val[2*n+1];
                t_idx[n] = t_idx[2*n+1];
            end
        end
        victim = t_idx[0];
    end

    // Find the lowest way one step nearer MRU than the hit way
    always_comb
    begin
        hit_in_range = int'(op.hit_way) < WAYS;
        orig         = pos[op.hit_way];
        target       = orig - POS_W'(1);
        found        = 1'b0;
        swap_way     = '0;
        for (int w = NWAYS - 1; w >= 0; w--)
        begin
            if (w < WAYS && pos[w] == target)
            begin
                found    = 1'b1;
                swap_way = WAY_W'(w);
            end
        end
        do_promote = op.attempt && hit_in_range && (orig != '0) && found;
    end

    // Build the updated row and the result
    always_comb
    begin
        for (int w = 0; w < NWAYS; w++)
        begin
            pos_new[w] = pos[w];
            if (op.kind == pipp_pkg::KIND_MISS)
            begin
                if (pos[w] >= op.ins && pos[w] < LAST_POS)
                begin
                    pos_new[w] = pos[w] + POS_W'(1);
                end
                if (WAY_W'(w) == victim)
                begin
                    pos_new[w] = op.ins;
                end
            end
            else if (do_promote)
            begin
                if (WAY_W'(w) == swap_way)
                begin
                    pos_new[w] = orig;
                end
                else if (WAY_W'(w) == op.hit_way)
                begin
                    pos_new[w] = target;
                end
            end
        end

        if (op.kind == pipp_pkg::KIND_MISS)
        begin
            res.victim   = victim;
            res.ins      = op.ins[WAY_W-1:0];
            res.promoted = 1'b0;
        end
        else
        begin
            res.victim   = '0;
            res.ins      = '0;
            res.promoted = do_promote;
        end
    end

endmodule

@@ design/pipp_insertion_promotion_policy.sv @@
// Channel   Handshake                     Payload
// access    start in, busy out            kind, set_index, hit_way, allocation,
//                                         requester_streaming, all_streaming,
//                                         streaming_count, replaceable_mask, random_draw
// result    done out (one-cycle strobe)   victim_way, insert_position, promoted
// config    cfg_valid in, cfg_ready out   cfg_data (min insert distance)
//
// In an access the set row is read from the row memory at the accept edge, then
// updated and written back in the next cycle; the result strobes in the cycle
// after that, while the next access may already be accepted.
// After reset a clearing pass writes every set row, with busy high.
// The result channel has no back-pressure; cfg_ready is always high.
module pipp_insertion_promotion_policy #(
    parameter int WAYS = 16,
    parameter int SETS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [pipp_pkg::SET_IN_W-1:0] set_index,
    input  logic [pipp_pkg::WAY_W-1:0]    hit_way,
    input  logic [pipp_pkg::CNT_W-1:0]    allocation,
    input  logic                          requester_streaming,
    input  logic                          all_streaming,
    input  logic [pipp_pkg::CNT_W-1:0]    streaming_count,
    input  logic [pipp_pkg::MASK_W-1:0]   replaceable_mask,
    input  logic [pipp_pkg::DRAW_W-1:0]   random_draw,

    output logic                          done,
    output logic [pipp_pkg::WAY_W-1:0]    victim_way,
    output logic [pipp_pkg::WAY_W-1:0]    insert_position,
    output logic                          promoted,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pipp_pkg::CNT_W-1:0]    cfg_data
);

    localparam int POS_W = pipp_pkg::POS_W;
    localparam int CNT_W = pipp_pkg::CNT_W;
    localparam int ROW_W = WAYS * POS_W;
    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam logic [CNT_W-1:0] WAYS_C = CNT_W'(WAYS);
    // Reciprocal of SETS scaled by 2^12, exact for every 6-bit set index
    localparam int SET_RECIP = (4096 + SETS - 1) / SETS;

    // Row with way i at position i
    function automatic logic [ROW_W-1:0] reset_row();
        logic [ROW_W-1:0] r;
        r = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            r[w*POS_W +: POS_W] = POS_W'(w);
        end
        return r;
    endfunction

    // Set index modulo SETS: reciprocal multiply for the quotient, then subtract
    function automatic logic [SET_W-1:0] set_of(logic [pipp_pkg::SET_IN_W-1:0] s);
        logic [31:0] q;
        logic [31:0] r;
        q = (32'(s) * 32'(SET_RECIP)) >> 12;
        r = 32'(s) - q * 32'(SETS);
        return r[SET_W-1:0];
    endfunction

    localparam logic [ROW_W-1:0] RESET_ROW = reset_row();

    pipp_pkg::state_t state_reg, state_next;
    pipp_pkg::op_t    op_reg, op_next;
    pipp_pkg::res_t   res_reg, res_new;
    logic [SET_W-1:0] set_reg;
    logic [SET_W-1:0] clr_idx_reg;
    logic [CNT_W-1:0] mid_reg;
    logic             done_reg;
    logic [ROW_W-1:0] rd_data_reg;
    logic [ROW_W-1:0] row_new;
    logic [ROW_W-1:0] row_mem [SETS];

    logic             accept;
    logic             mem_we;
    logic [SET_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [CNT_W-1:0] alloc_eff;
    logic [CNT_W-1:0] raw_ins;
    logic [CNT_W-1:0] cap;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Insert position and promotion decision from the access fields
    always_comb
    begin
        alloc_eff = (allocation == '0) ? CNT_W'(1) : allocation;
        if (requester_streaming)
        begin
            if (all_streaming)
            begin
                raw_ins = '0;
            end
            else
            begin
                raw_ins = (streaming_count >= WAYS_C) ? '0 : WAYS_C - streaming_count;
            end
        end
        else
        begin
            raw_ins = (alloc_eff >= WAYS_C) ? '0 : WAYS_C - alloc_eff;
        end
        cap = (mid_reg >= WAYS_C) ? '0 : WAYS_C - mid_reg;

        op_next.kind    = kind;
        op_next.hit_way = hit_way;
        op_next.ins     = POS_W'((raw_ins > cap) ? cap : raw_ins);
        op_next.mask    = replaceable_mask;
        op_next.attempt = requester_streaming ? (random_draw == '0)
                                              : (random_draw[1:0] < pipp_pkg::PROMOTE_NORMAL_LIMIT);
    end

    // Row update for the set being worked on
    pipp_row_update #(
        .WAYS (WAYS)
    ) u_row_update (
        .row     (rd_data_reg),
        .op      (op_reg),
        .row_new (row_new),
        .res     (res_new)
    );

    // Next state and memory write control
    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = set_reg;
        mem_wdata  = row_new;
        unique case (state_reg)
            pipp_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_idx_reg;
                mem_wdata = RESET_ROW;
                if (clr_idx_reg == SET_W'(SETS - 1))
                begin
                    state_next = pipp_pkg::ST_IDLE;
                end
            end
            pipp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pipp_pkg::ST_EXEC;
                end
            end
            pipp_pkg::ST_EXEC:
            begin
                mem_we     = 1'b1;
                state_next = pipp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pipp_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != pipp_pkg::ST_IDLE);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pipp_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            mid_reg     <= pipp_pkg::MID_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == pipp_pkg::ST_EXEC);
            if (state_reg == pipp_pkg::ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + SET_W'(1);
            end
            if (cfg_valid && cfg_ready)
            begin
                mid_reg <= cfg_data;
            end
        end
    end

    // Capture the access and the result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_next;
            set_reg <= set_of(set_index);
        end
        if (state_reg == pipp_pkg::ST_EXEC)
        begin
            res_reg <= res_new;
        end
    end

    // Row memory: write back updated rows, read the addressed set on transfer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= row_mem[set_of(set_index)];
        end
    end

    assign done            = done_reg;
    assign victim_way      = res_reg.victim;
    assign insert_position = res_reg.ins;
    assign promoted        = res_reg.promoted;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == pipp_pkg::ST_EXEC))
        else $error("result strobe without a preceding update cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == pipp_pkg::ST_EXEC) && mem_we)
        else $error("accepted access did not enter the update cycle");

    a_miss_no_promote: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg.kind == pipp_pkg::KIND_MISS) |-> !promoted)
        else $error("miss reported a promotion");

    a_hit_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg.kind == pipp_pkg::KIND_HIT) |-> (victim_way == '0)
            && (insert_position == '0))
        else $error("hit reported a victim or insert position");

endmodule
